// File: rtl/core/firvm_pkg.sv
`default_nettype none

package firvm_pkg;

	localparam int unsigned SAMPLE_BITS   = 16;
	localparam int unsigned COEF_BITS     = 16;
	localparam int unsigned PROD_BITS     = SAMPLE_BITS + COEF_BITS;
	localparam int unsigned OUT_BITS      = 35;
	localparam int unsigned TAP_BITS      = 3;
	localparam int unsigned NUM_COEFS     = 7;
	localparam int unsigned DEF_MAX_TAPS  = 7;
	localparam int unsigned CFG_IDX_BITS  = 3;
	localparam int unsigned CFG_DATA_BITS = 16;

	localparam logic [TAP_BITS-1:0]  TAP_COUNT_RESET = TAP_BITS'(1);
	localparam logic [COEF_BITS-1:0] COEF_0_RESET    = COEF_BITS'(32767);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_COEF_0    = 3'd1,
		REG_COEF_1    = 3'd2,
		REG_COEF_2    = 3'd3,
		REG_COEF_3    = 3'd4,
		REG_COEF_4    = 3'd5,
		REG_COEF_5    = 3'd6,
		REG_COEF_6    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          first;
		logic                          last;
	} src_item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] filtered;
		logic                       end_of_waveform;
	} res_item_t;

	// control that rides along with the sum pipeline
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

	// exact product, sign extended to the result width
	function automatic logic signed [OUT_BITS-1:0] tap_product(
		input logic signed [SAMPLE_BITS-1:0] s,
		input logic signed [COEF_BITS-1:0]   c
	);
		logic signed [PROD_BITS-1:0] p;
		p = s * c;
		return OUT_BITS'(p);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/firvm_tap_cell.sv
`default_nettype none

module firvm_tap_cell
	import firvm_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire logic                          shift,
	input  wire logic signed [SAMPLE_BITS-1:0] tap_in,
	input  wire logic signed [COEF_BITS-1:0]   tap_coef,
	output logic signed [SAMPLE_BITS-1:0]      tap_q,
	output logic signed [OUT_BITS-1:0]         prod_s1
);

	// sample moves one cell down the line per accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= tap_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1 <= tap_product(tap_in, tap_coef);
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/firvm_add_tree.sv
`default_nettype none

module firvm_add_tree
	import firvm_pkg::*;
#(
	parameter int unsigned NUM_LEAF = DEF_MAX_TAPS
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire logic signed [OUT_BITS-1:0] leaf [NUM_LEAF],
	input  wire tag_t                       tag_in,
	output logic signed [OUT_BITS-1:0]      root,
	output tag_t                            tag_out
);

	localparam int unsigned LEVELS = $clog2(NUM_LEAF);
	localparam int unsigned LEAVES = 1 << LEVELS;

	generate
		if (LEVELS == 0) begin : g_single
			assign root    = leaf[0];
			assign tag_out = tag_in;
		end else begin : g_tree
			logic signed [OUT_BITS-1:0] leaf_w [LEAVES];
			// heap order: node 1 is the root, children of node i are 2i and 2i+1
			logic signed [OUT_BITS-1:0] node_q [1:LEAVES-1];
			tag_t                       tag_q  [LEVELS];

			for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
				if (i < NUM_LEAF) begin : g_used
					assign leaf_w[i] = leaf[i];
				end else begin : g_pad
					assign leaf_w[i] = '0;
				end
			end

			for (genvar i = 1; i < LEAVES; i++) begin : g_node
				logic signed [OUT_BITS-1:0] lhs;
				logic signed [OUT_BITS-1:0] rhs;
				if (2 * i >= LEAVES) begin : g_bottom
					assign lhs = leaf_w[2 * i - LEAVES];
					assign rhs = leaf_w[2 * i + 1 - LEAVES];
				end else begin : g_inner
					assign lhs = node_q[2 * i];
					assign rhs = node_q[2 * i + 1];
				end
				always_ff @(posedge clk) begin
					if (adv) begin
						node_q[i] <= lhs + rhs;
					end
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					for (int l = 0; l < LEVELS; l++) begin
						tag_q[l] <= '0;
					end
				end else if (adv) begin
					tag_q[0] <= tag_in;
					for (int l = 1; l < LEVELS; l++) begin
						tag_q[l] <= tag_q[l-1];
					end
				end
			end

			assign root    = node_q[1];
			assign tag_out = tag_q[LEVELS-1];
		end
	endgenerate

endmodule

`default_nettype wire

// File: rtl/core/fir_filter_valid_mode.sv
`default_nettype none

// Streaming valid-mode FIR: each accepted sample enters a row of tap cells that hold the
// previous samples of the current waveform and multiply each window position by its
// coefficient; once tap_count samples of the waveform have arrived every sample yields one
// exact 35-bit sum (coef_0 on the oldest sample), flagged end_of_waveform on the last one.
// Waveforms shorter than tap_count give nothing. One sample is taken per clock unless the
// pipe is stalled; a result is registered first by the per-tap multipliers, then once per
// level of the registered adder tree. A stall on the result side holds the whole pipe, so
// the sample side stalls only while a result is held. Configuration is to be written while
// the filter is idle, which the block itself does not enforce; tap_count of zero acts as one
// tap and values above MAX_TAPS act as MAX_TAPS.

module fir_filter_valid_mode
	import firvm_pkg::*;
#(
	parameter int unsigned MAX_TAPS = DEF_MAX_TAPS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     src_valid,
	output logic                          src_stall,
	input  wire src_item_t                src_data,
	output logic                          res_valid,
	input  wire logic                     res_stall,
	output res_item_t                     res_data,
	input  wire logic                     cfg_wr_en,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

	logic [TAP_BITS-1:0]        tap_count_q;
	logic signed [COEF_BITS-1:0] coef_q [NUM_COEFS];
	logic [TAP_BITS-1:0]        fill_q;
	logic [TAP_BITS-1:0]        taps;
	logic [TAP_BITS-1:0]        fill_base;
	logic [TAP_BITS-1:0]        fill_next;
	logic                       produce;
	logic                       accept;
	logic                       adv;
	tag_t                       tag_s1;
	tag_t                       tag_out;
	logic signed [OUT_BITS-1:0] root;

	logic signed [SAMPLE_BITS-1:0] tap_w    [MAX_TAPS+1];
	logic signed [COEF_BITS-1:0]   tap_coef [MAX_TAPS];
	logic signed [OUT_BITS-1:0]    prod_s1  [MAX_TAPS];

	assign src_stall = res_valid && res_stall;
	assign adv       = !src_stall;
	assign accept    = src_valid && !src_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TAP_COUNT_RESET;
			coef_q[0]   <= COEF_0_RESET;
			for (int i = 1; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_TAP_COUNT) begin
				tap_count_q <= cfg_data[TAP_BITS-1:0];
			end else begin
				coef_q[TAP_BITS'(cfg_index - CFG_IDX_BITS'(REG_COEF_0))] <= cfg_data;
			end
		end
	end

	always_comb begin
		taps = tap_count_q;
		if (tap_count_q == '0) begin
			taps = TAP_BITS'(1);
		end else if (tap_count_q > TAP_BITS'(MAX_TAPS)) begin
			taps = TAP_BITS'(MAX_TAPS);
		end
	end

	// fill count of the current waveform
	always_comb begin
		fill_base = src_data.first ? '0 : fill_q;
		produce   = fill_base >= (taps - TAP_BITS'(1));
		if (src_data.last) begin
			fill_next = '0;
		end else if (fill_base < TAP_BITS'(MAX_TAPS - 1)) begin
			fill_next = fill_base + TAP_BITS'(1);
		end else begin
			fill_next = fill_base;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1.valid <= accept && produce;
			tag_s1.last  <= src_data.last;
		end
	end

	// cell k sees the sample k places back; it weights it with coef[taps-1-k]
	assign tap_w[0] = src_data.sample;

	generate
		for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
			assign tap_coef[k] = (TAP_BITS'(k) < taps)
				? coef_q[TAP_BITS'(taps - TAP_BITS'(k) - TAP_BITS'(1))] : '0;

			firvm_tap_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.adv      (adv),
				.shift    (accept),
				.tap_in   (tap_w[k]),
				.tap_coef (tap_coef[k]),
				.tap_q    (tap_w[k+1]),
				.prod_s1  (prod_s1[k])
			);
		end
	endgenerate

	firvm_add_tree #(
		.NUM_LEAF (MAX_TAPS)
	) u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.leaf    (prod_s1),
		.tag_in  (tag_s1),
		.root    (root),
		.tag_out (tag_out)
	);

	assign res_valid                = tag_out.valid;
	assign res_data.filtered        = root;
	assign res_data.end_of_waveform = tag_out.last;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= TAP_BITS'(MAX_TAPS - 1))
		else $error("fill count above window depth");

	a_taps_range: assert property (@(posedge clk) disable iff (!arst_n)
		taps != '0 && taps <= TAP_BITS'(MAX_TAPS))
		else $error("taps in use out of range");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_data.last |=> fill_q == '0)
		else $error("last sample did not end the waveform");

	a_first_short: assert property (@(posedge clk) disable iff (!arst_n)
		accept && src_data.first && taps != TAP_BITS'(1) |=> !tag_s1.valid)
		else $error("result from an incomplete window");

endmodule

`default_nettype wire

// File: verif/fir_filter_valid_mode_test.sv
`timescale 1ns / 100ps

module fir_filter_valid_mode_test;
	import firvm_pkg::*;

	localparam int unsigned HIST_DEPTH   = DEF_MAX_TAPS - 1;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned HOLD_CYCLES  = 120;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	src_item_t src_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_item_t res_data;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	// filter state as the testbench sees it
	logic [TAP_BITS-1:0] taps_reg = TAP_COUNT_RESET;
	logic signed [COEF_BITS-1:0] coef_reg [NUM_COEFS];
	logic signed [SAMPLE_BITS-1:0] window_hist [HIST_DEPTH];
	int unsigned fill_level = 0;
	res_item_t pending_sums [$];

	bit src_idle_en = 1'b1;
	bit res_idle_en = 1'b1;
	bit hold_req = 1'b0;
	int unsigned hold_left = 0;

	int unsigned error_count = 0;
	int unsigned samples_sent = 0;
	int unsigned waveforms_sent = 0;
	int unsigned sums_checked = 0;
	int unsigned ends_seen = 0;
	int unsigned input_stall_cycles = 0;

	fir_filter_valid_mode i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		foreach (coef_reg[k]) coef_reg[k] = '0;
		coef_reg[0] = COEF_0_RESET;
		foreach (window_hist[k]) window_hist[k] = '0;
	end

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	// window sum for one accepted sample; updates history and fill level
	function automatic void predict_filtered(input src_item_t item);
		int unsigned taps;
		longint acc;
		res_item_t exp_item;
		taps = (taps_reg == 0) ? 1 : taps_reg;
		if (item.first)
			fill_level = 0;
		if (fill_level + 1 >= taps) begin
			acc = longint'(coef_reg[taps-1]) * longint'(item.sample);
			for (int j = 0; j + 1 < taps; j++)
				acc += longint'(coef_reg[taps-2-j]) * longint'(window_hist[j]);
			exp_item.filtered = acc[OUT_BITS-1:0];
			exp_item.end_of_waveform = item.last;
			pending_sums.push_back(exp_item);
		end
		for (int j = HIST_DEPTH - 1; j > 0; j--)
			window_hist[j] = window_hist[j-1];
		window_hist[0] = item.sample;
		if (fill_level < HIST_DEPTH)
			fill_level++;
		if (item.last)
			fill_level = 0;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(7))
			0: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
			1: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic void rand_coefs(output logic signed [COEF_BITS-1:0] c [NUM_COEFS]);
		foreach (c[k]) begin
			case ($urandom_range(7))
				0: c[k] = -16'sd32768;
				1: c[k] = 16'sd32767;
				default: c[k] = COEF_BITS'($urandom);
			endcase
		end
	endfunction

	task automatic send_sample(input src_item_t item);
		int gap;
		gap = 0;
		if (src_idle_en)
			while ($urandom_range(99) < 31 && gap < 40) gap++;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data <= item;
		@(posedge clk);
		while (src_stall) @(posedge clk);
		predict_filtered(item);
		samples_sent++;
	endtask

	task automatic send_flagged(input logic signed [SAMPLE_BITS-1:0] s,
		input logic first_flag, input logic last_flag);
		src_item_t item;
		item.sample = s;
		item.first = first_flag;
		item.last = last_flag;
		send_sample(item);
	endtask

	// mostly well-formed waveforms, some with stray or missing flags
	task automatic send_waveforms(input int n_items);
		int sent;
		int len;
		src_item_t item;
		sent = 0;
		while (sent < n_items) begin
			len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 24);
			waveforms_sent++;
			for (int i = 0; i < len; i++) begin
				item.sample = rand_sample();
				item.first = (i == 0);
				item.last = (i == len - 1);
				if ($urandom_range(9) == 0) item.first = 1'($urandom_range(1));
				if ($urandom_range(9) == 0) item.last = 1'($urandom_range(1));
				send_sample(item);
				sent++;
			end
		end
	endtask

	// lower valid, let every result out, then let the pipe run empty
	task automatic wait_pipeline_empty();
		bit saved;
		src_valid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		saved = res_idle_en;
		res_idle_en = 1'b0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		res_idle_en = saved;
	endtask

	task automatic load_filter(input logic [TAP_BITS-1:0] taps,
		input logic signed [COEF_BITS-1:0] c [NUM_COEFS]);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_TAP_COUNT;
		cfg_data <= CFG_DATA_BITS'(taps);
		@(posedge clk);
		taps_reg = taps;
		for (int k = 0; k < NUM_COEFS; k++) begin
			cfg_index <= cfg_reg_t'(REG_COEF_0 + k);
			cfg_data <= c[k];
			@(posedge clk);
			coef_reg[k] = c[k];
		end
		cfg_wr_en <= 1'b0;
	endtask

	// single-tap defaults, extremes of the sample, one-sample waveform
	task automatic test_reset_defaults();
		send_flagged(16'sd32767, 1'b1, 1'b0);
		send_flagged(-16'sd32768, 1'b0, 1'b0);
		send_flagged(-16'sd1, 1'b0, 1'b1);
		send_flagged(16'sd1234, 1'b1, 1'b1);
		wait_pipeline_empty();
	endtask

	// largest positive and negative sums with all seven taps
	task automatic test_extreme_sums();
		logic signed [COEF_BITS-1:0] c [NUM_COEFS];
		foreach (c[k]) c[k] = -16'sd32768;
		load_filter(3'd7, c);
		for (int i = 0; i < 7; i++)
			send_flagged(-16'sd32768, i == 0, i == 6);
		wait_pipeline_empty();
		foreach (c[k]) c[k] = 16'sd32767;
		load_filter(3'd7, c);
		for (int i = 0; i < 7; i++)
			send_flagged(-16'sd32768, i == 0, i == 6);
		wait_pipeline_empty();
	endtask

	// restart mid-waveform, implicit start, short waveforms, zero tap count
	task automatic test_waveform_edges();
		logic signed [COEF_BITS-1:0] c [NUM_COEFS];
		rand_coefs(c);
		load_filter(3'd2, c);
		send_flagged(rand_sample(), 1'b1, 1'b0);
		send_flagged(rand_sample(), 1'b0, 1'b0);
		send_flagged(rand_sample(), 1'b1, 1'b0);
		send_flagged(rand_sample(), 1'b0, 1'b1);
		send_flagged(rand_sample(), 1'b0, 1'b0);
		send_flagged(rand_sample(), 1'b0, 1'b1);
		send_flagged(rand_sample(), 1'b1, 1'b1);
		wait_pipeline_empty();
		load_filter(3'd0, c);
		send_flagged(rand_sample(), 1'b1, 1'b1);
		wait_pipeline_empty();
	endtask

	task automatic test_random_waveforms();
		logic signed [COEF_BITS-1:0] c [NUM_COEFS];
		logic [TAP_BITS-1:0] phase_taps [4] = '{3'd7, 3'd1, 3'd4, 3'd0};
		foreach (phase_taps[p]) begin
			rand_coefs(c);
			load_filter(phase_taps[p], c);
			send_waveforms(120);
			wait_pipeline_empty();
		end
	endtask

	task automatic test_no_idle_stretch();
		logic signed [COEF_BITS-1:0] c [NUM_COEFS];
		rand_coefs(c);
		load_filter(3'd6, c);
		src_idle_en = 1'b0;
		res_idle_en = 1'b0;
		send_waveforms(150);
		src_idle_en = 1'b1;
		res_idle_en = 1'b1;
		wait_pipeline_empty();
	endtask

	// receiver holds off while samples keep coming, so the input must stall
	task automatic test_output_backpressure();
		logic signed [COEF_BITS-1:0] c [NUM_COEFS];
		rand_coefs(c);
		load_filter(3'd5, c);
		src_idle_en = 1'b0;
		hold_req = 1'b1;
		send_waveforms(100);
		src_idle_en = 1'b1;
		wait_pipeline_empty();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else if (res_idle_en)
			res_stall <= ($urandom_range(99) < 31);
		else
			res_stall <= 1'b0;
	end

	always @(posedge clk) begin
		res_item_t exp_item;
		if (arst_n) begin
			if (src_valid && src_stall)
				input_stall_cycles++;
			if (res_valid && !res_stall) begin
				if (pending_sums.size() == 0)
					report_mismatch($sformatf("unexpected result filtered=%0d end=%0b",
						res_data.filtered, res_data.end_of_waveform));
				else begin
					exp_item = pending_sums.pop_front();
					sums_checked++;
					if (exp_item.end_of_waveform)
						ends_seen++;
					if (res_data.filtered !== exp_item.filtered)
						report_mismatch($sformatf("filtered: got %0d, want %0d",
							res_data.filtered, exp_item.filtered));
					if (res_data.end_of_waveform !== exp_item.end_of_waveform)
						report_mismatch($sformatf("end_of_waveform: got %0b, want %0b",
							res_data.end_of_waveform, exp_item.end_of_waveform));
				end
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_extreme_sums();
		test_waveform_edges();
		test_random_waveforms();
		test_no_idle_stretch();
		test_output_backpressure();
		if (pending_sums.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_sums.size()));
		$display("Sent %0d samples in %0d random waveforms plus directed cases, %0d sums checked",
			samples_sent, waveforms_sent, sums_checked);
		$display("%0d end marks delivered, %0d cycles of input backpressure observed",
			ends_seen, input_stall_cycles);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout: %0d results still outstanding", pending_sums.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
